// ===== sv/huffman_tree_load_and_decode_defines.svh =====
// Assertion macros for the Huffman tree decoder.
`ifndef HUFFMAN_TREE_LOAD_AND_DECODE_DEFINES_SVH
`define HUFFMAN_TREE_LOAD_AND_DECODE_DEFINES_SVH

`ifndef ASSERT_OFF

// prop holds at every rising clock edge outside reset
`define HUFD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("hufd assertion failed");

// expr never holds outside reset
`define HUFD_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("hufd forbidden condition seen");

`else

`define HUFD_ASSERT(lbl, clk, rst, prop)
`define HUFD_ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

// ===== sv/hufd_pkg.sv =====
`default_nettype none

package hufd_pkg;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_TREE  = 2'd1;
   localparam logic [1:0] ACT_BIT   = 2'd2;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_TREE  = 2'd1;
   localparam logic [1:0] OP_BIT   = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [1:0] FAULT_NONE  = 2'd0;
   localparam logic [1:0] FAULT_TREE  = 2'd1;
   localparam logic [1:0] FAULT_EARLY = 2'd2;

   localparam logic [7:0] LEAF_FLAG = 8'h01;

   // pending stack: 256 entries, depth counter one bit wider
   localparam int PEND_AW = 8;
   localparam int PEND_DEPTH = 1 << PEND_AW;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW = 1;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] tree_byte;
      logic       code_bit;
   } cmd_type;

endpackage

`default_nettype wire

// ===== sv/hufd_front.sv =====
`default_nettype none

module hufd_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic [1:0]      req_action,
   input  wire logic [7:0]      req_tree_byte,
   input  wire logic            req_code_bit,
   output logic                 cmd_valid,
   output hufd_pkg::cmd_type    cmd,
   input  wire logic            cmd_pop
);
   import hufd_pkg::*;

   cmd_type              q_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]    count_ff, count_in;
   logic                 enq;
   logic                 deq;
   cmd_type              cls;

   always_comb begin
      cls.tree_byte = req_tree_byte;
      cls.code_bit  = req_code_bit;
      case (req_action)
         ACT_CLEAR: cls.op = OP_CLEAR;
         ACT_TREE:  cls.op = OP_TREE;
         ACT_BIT:   cls.op = OP_BIT;
         default:   cls.op = OP_NONE;
      endcase
   end

   assign req_stall = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign enq       = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign deq       = cmd_pop && cmd_valid;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = enq ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = deq ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (enq && !deq) begin
         count_in = count_ff + 1'b1;
      end else if (!enq && deq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

// ===== sv/hufd_back.sv =====
`default_nettype none

module hufd_back #(
   parameter int SYMBOLS   = 256,
   parameter int MAX_NODES = 511
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            cmd_valid,
   input  wire hufd_pkg::cmd_type cmd,
   output logic                 cmd_pop,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output logic                 rsp_symbol_valid,
   output logic [7:0]           rsp_symbol,
   output logic                 rsp_tree_ready,
   output logic [1:0]           rsp_fault
);
   import hufd_pkg::*;

   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int NW = $clog2(MAX_NODES + 1);
   localparam logic [NW-1:0] NODE_LIMIT = NW'(MAX_NODES);
   localparam logic [8:0]    SYM_LIMIT  = 9'(SYMBOLS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_POP  = 2'd1;
   localparam logic [1:0] ST_WALK = 2'd2;

   localparam logic PH_FLAG = 1'b0;
   localparam logic PH_SYM  = 1'b1;

   // node table, one array per field
   logic          leaf_mem  [MAX_NODES];
   logic [7:0]    sym_mem   [MAX_NODES];
   logic [NW-1:0] right_mem [MAX_NODES];
   logic [AW-1:0] stk_mem   [PEND_DEPTH];

   logic [1:0]       state_ff, state_in;
   logic [NW-1:0]    node_count_ff, node_count_in;
   logic [PEND_AW:0] depth_ff, depth_in;
   logic [AW-1:0]    walk_node_ff, walk_node_in;
   logic [NW-1:0]    walk_right_ff, walk_right_in;
   logic [AW-1:0]    walk_nxt_ff, walk_nxt_in;
   logic             phase_ff, phase_in;
   logic             complete_ff, complete_in;
   logic             root_leaf_ff, root_leaf_in;
   logic [7:0]       root_sym_ff, root_sym_in;
   logic [NW-1:0]    root_right_ff, root_right_in;

   logic             rd_leaf_ff;
   logic [7:0]       rd_sym_ff;
   logic [NW-1:0]    rd_right_ff;
   logic [AW-1:0]    rd_addr;
   logic [AW-1:0]    stk_rd_ff;
   logic [PEND_AW-1:0] stk_ra;

   logic             leaf_we, sym_we, right_we, stk_we;
   logic [AW-1:0]    leaf_wa, sym_wa, right_wa;
   logic             leaf_wd;
   logic [7:0]       sym_wd;
   logic [NW-1:0]    right_wd;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_sv_ff;
   logic [7:0]       rsp_sym_ff;
   logic             rsp_ready_ff;
   logic [1:0]       rsp_fault_ff;

   logic             out_free;
   logic             res_load;
   logic             res_sv;
   logic [7:0]       res_sym;
   logic [1:0]       res_fault;
   logic [NW-1:0]    nxt;
   logic [NW-1:0]    nc_dec;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign stk_ra   = PEND_AW'(depth_ff - 1'b1);
   assign nc_dec   = node_count_ff - 1'b1;

   always_comb begin
      nxt = cmd.code_bit ? walk_right_ff : NW'(walk_node_ff) + 1'b1;
      if (nxt >= NODE_LIMIT) begin
         nxt = '0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      node_count_in = node_count_ff;
      depth_in      = depth_ff;
      walk_node_in  = walk_node_ff;
      walk_right_in = walk_right_ff;
      walk_nxt_in   = walk_nxt_ff;
      phase_in      = phase_ff;
      complete_in   = complete_ff;
      root_leaf_in  = root_leaf_ff;
      root_sym_in   = root_sym_ff;
      root_right_in = root_right_ff;
      cmd_pop       = 1'b0;
      res_load      = 1'b0;
      res_sv        = 1'b0;
      res_sym       = '0;
      res_fault     = FAULT_NONE;
      leaf_we       = 1'b0;
      sym_we        = 1'b0;
      right_we      = 1'b0;
      stk_we        = 1'b0;
      leaf_wa       = node_count_ff[AW-1:0];
      sym_wa        = node_count_ff[AW-1:0];
      right_wa      = node_count_ff[AW-1:0];
      leaf_wd       = 1'b0;
      sym_wd        = '0;
      right_wd      = '0;
      rd_addr       = nxt[AW-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  OP_CLEAR: begin
                     node_count_in = '0;
                     depth_in      = '0;
                     walk_node_in  = '0;
                     phase_in      = PH_FLAG;
                     complete_in   = 1'b0;
                     res_load      = 1'b1;
                  end
                  OP_TREE: begin
                     res_load = 1'b1;
                     if (complete_ff) begin
                        res_fault = FAULT_TREE;
                     end else if (phase_ff == PH_FLAG) begin
                        if (node_count_ff >= NODE_LIMIT) begin
                           res_fault = FAULT_TREE;
                        end else if (cmd.tree_byte != LEAF_FLAG && depth_ff[PEND_AW]) begin
                           res_fault = FAULT_TREE;
                        end else begin
                           leaf_we       = 1'b1;
                           sym_we        = 1'b1;
                           right_we      = 1'b1;
                           leaf_wd       = (cmd.tree_byte == LEAF_FLAG);
                           node_count_in = node_count_ff + 1'b1;
                           if (node_count_ff == '0) begin
                              root_leaf_in  = (cmd.tree_byte == LEAF_FLAG);
                              root_sym_in   = '0;
                              root_right_in = '0;
                           end
                           if (cmd.tree_byte == LEAF_FLAG) begin
                              phase_in = PH_SYM;
                           end else begin
                              stk_we   = 1'b1;
                              depth_in = depth_ff + 1'b1;
                           end
                        end
                     end else if ({1'b0, cmd.tree_byte} >= SYM_LIMIT) begin
                        res_fault = FAULT_TREE;
                     end else begin
                        sym_we   = 1'b1;
                        sym_wa   = nc_dec[AW-1:0];
                        sym_wd   = cmd.tree_byte;
                        phase_in = PH_FLAG;
                        if (nc_dec == '0) begin
                           root_sym_in = cmd.tree_byte;
                        end
                        if (depth_ff == '0) begin
                           complete_in   = 1'b1;
                           walk_node_in  = '0;
                           walk_right_in = root_right_ff;
                        end else begin
                           depth_in = depth_ff - 1'b1;
                           res_load = 1'b0;
                           state_in = ST_POP;
                        end
                     end
                  end
                  OP_BIT: begin
                     if (!complete_ff) begin
                        res_fault = FAULT_EARLY;
                        res_load  = 1'b1;
                     end else if (root_leaf_ff) begin
                        res_sv       = 1'b1;
                        res_sym      = root_sym_ff;
                        walk_node_in = '0;
                        res_load     = 1'b1;
                     end else begin
                        walk_nxt_in = nxt[AW-1:0];
                        state_in    = ST_WALK;
                     end
                  end
                  default: begin
                     res_load = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            right_we = 1'b1;
            right_wa = stk_rd_ff;
            right_wd = node_count_ff;
            if (stk_rd_ff == '0) begin
               root_right_in = node_count_ff;
            end
            res_load = 1'b1;
            state_in = ST_IDLE;
         end
         ST_WALK: begin
            if (rd_leaf_ff) begin
               res_sv        = 1'b1;
               res_sym       = rd_sym_ff;
               walk_node_in  = '0;
               walk_right_in = root_right_ff;
            end else begin
               walk_node_in  = walk_nxt_ff;
               walk_right_in = rd_right_ff;
            end
            res_load = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = res_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= '0;
         depth_ff      <= '0;
         walk_node_ff  <= '0;
         phase_ff      <= PH_FLAG;
         complete_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         depth_ff      <= depth_in;
         walk_node_ff  <= walk_node_in;
         phase_ff      <= phase_in;
         complete_ff   <= complete_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_right_ff <= walk_right_in;
      walk_nxt_ff   <= walk_nxt_in;
      root_leaf_ff  <= root_leaf_in;
      root_sym_ff   <= root_sym_in;
      root_right_ff <= root_right_in;
      if (res_load) begin
         rsp_sv_ff    <= res_sv;
         rsp_sym_ff   <= res_sym;
         rsp_ready_ff <= complete_in;
         rsp_fault_ff <= res_fault;
      end
   end

   always_ff @(posedge clock) begin
      if (leaf_we) begin
         leaf_mem[leaf_wa] <= leaf_wd;
      end
      rd_leaf_ff <= leaf_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (sym_we) begin
         sym_mem[sym_wa] <= sym_wd;
      end
      rd_sym_ff <= sym_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (right_we) begin
         right_mem[right_wa] <= right_wd;
      end
      rd_right_ff <= right_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[depth_ff[PEND_AW-1:0]] <= node_count_ff[AW-1:0];
      end
      stk_rd_ff <= stk_mem[stk_ra];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_symbol_valid = rsp_sv_ff;
   assign rsp_symbol       = rsp_sym_ff;
   assign rsp_tree_ready   = rsp_ready_ff;
   assign rsp_fault        = rsp_fault_ff;

endmodule

`default_nettype wire

// ===== sv/huffman_tree_load_and_decode.sv =====
// Channel  Handshake           Beat payload
// req      req_valid/req_stall req_action, req_tree_byte, req_code_bit
// rsp      rsp_valid/rsp_stall rsp_symbol_valid, rsp_symbol, rsp_tree_ready, rsp_fault
//
// Each req beat gives exactly one rsp beat, in order, through a two-entry command queue.
// Code bit: node table read, then step; a single-leaf tree answers it directly.
// Leaf symbol with nodes still pending: stack read, then right link write.
// Other beats are answered directly; a new command waits until the last one is done.
// Reset is synchronous; the node table and stack need no clearing.
// rsp_stall holds the output register; req is stalled only when the queue is full.
`default_nettype none

`include "huffman_tree_load_and_decode_defines.svh"

module huffman_tree_load_and_decode #(
   parameter int SYMBOLS   = 256,
   parameter int MAX_NODES = 511
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_action,
   input  wire logic [7:0] req_tree_byte,
   input  wire logic       req_code_bit,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_symbol_valid,
   output logic [7:0]      rsp_symbol,
   output logic            rsp_tree_ready,
   output logic [1:0]      rsp_fault
);
   import hufd_pkg::*;

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   hufd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_tree_byte (req_tree_byte),
      .req_code_bit  (req_code_bit),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   hufd_back #(
      .SYMBOLS   (SYMBOLS),
      .MAX_NODES (MAX_NODES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_symbol_valid (rsp_symbol_valid),
      .rsp_symbol       (rsp_symbol),
      .rsp_tree_ready   (rsp_tree_ready),
      .rsp_fault        (rsp_fault)
   );

   `HUFD_ASSERT(a_sym_clean, clock, reset, (rsp_valid && rsp_symbol_valid) |-> (rsp_fault == FAULT_NONE && rsp_tree_ready))
   `HUFD_ASSERT(a_early_not_ready, clock, reset, (rsp_valid && rsp_fault == FAULT_EARLY) |-> !rsp_tree_ready)
   `HUFD_ASSERT(a_no_sym_zero, clock, reset, (rsp_valid && !rsp_symbol_valid) |-> (rsp_symbol == 8'd0))
   `HUFD_ASSERT_NEVER(a_bad_fault, clock, reset, rsp_valid && rsp_fault == 2'd3)

endmodule

`default_nettype wire

// ===== tb/huffman_tree_load_and_decode_test.sv =====
`timescale 1ns / 100ps

module huffman_tree_load_and_decode_test;
   import hufd_pkg::*;

   localparam int SYMBOLS      = 256;
   localparam int MAX_NODES    = 511;
   localparam int IDLE_LIMIT   = 4000;
   localparam int TOTAL_BEATS  = 1350;

   typedef struct packed {
      logic       symbol_valid;
      logic [7:0] symbol;
      logic       tree_ready;
      logic [1:0] fault;
   } decode_result_type;

   class decode_scoreboard_type;
      bit                 is_leaf[MAX_NODES];
      bit [7:0]           leaf_sym[MAX_NODES];
      bit [8:0]           right_link[MAX_NODES];
      bit [8:0]           open_nodes[PEND_DEPTH];
      int unsigned        open_depth;
      int unsigned        nodes_used;
      bit [8:0]           walk_pos;
      bit                 want_symbol;
      bit                 tree_done;
      decode_result_type  expected_q[$];
      int                 errors;
      int                 beats;
      int                 symbols_decoded;
      int                 trees_done;
      int                 tree_faults;
      int                 early_faults;

      function void clear_tree();
         open_depth  = 0;
         nodes_used  = 0;
         walk_pos    = 0;
         want_symbol = 0;
         tree_done   = 0;
      endfunction

      function logic [1:0] load_byte(logic [7:0] b);
         if (tree_done) return FAULT_TREE;
         if (!want_symbol) begin
            if (nodes_used >= MAX_NODES) return FAULT_TREE;
            if (b == LEAF_FLAG) begin
               is_leaf[nodes_used]    = 1;
               leaf_sym[nodes_used]   = 0;
               right_link[nodes_used] = 0;
               nodes_used++;
               want_symbol = 1;
               return FAULT_NONE;
            end
            if (open_depth >= PEND_DEPTH) return FAULT_TREE;
            is_leaf[nodes_used]    = 0;
            leaf_sym[nodes_used]   = 0;
            right_link[nodes_used] = 0;
            open_nodes[open_depth] = 9'(nodes_used);
            open_depth++;
            nodes_used++;
            return FAULT_NONE;
         end
         if (int'(b) >= SYMBOLS) return FAULT_TREE;
         leaf_sym[nodes_used - 1] = b;
         want_symbol = 0;
         if (open_depth == 0) begin
            tree_done = 1;
            walk_pos  = 0;
            trees_done++;
         end else begin
            open_depth--;
            right_link[open_nodes[open_depth]] = 9'(nodes_used);
         end
         return FAULT_NONE;
      endfunction

      function void note_request(logic [1:0] act, logic [7:0] b, logic cb);
         decode_result_type r;
         int unsigned       nxt;
         r = '0;
         beats++;
         case (act)
            ACT_CLEAR: clear_tree();
            ACT_TREE:  r.fault = load_byte(b);
            ACT_BIT: begin
               if (!tree_done) begin
                  r.fault = FAULT_EARLY;
               end else begin
                  if (is_leaf[0]) begin
                     nxt = 0;
                  end else begin
                     nxt = cb ? int'(right_link[walk_pos]) : int'(walk_pos) + 1;
                     if (nxt >= MAX_NODES) nxt = 0;
                  end
                  if (is_leaf[nxt]) begin
                     r.symbol_valid = 1;
                     r.symbol       = leaf_sym[nxt];
                     walk_pos       = 0;
                     symbols_decoded++;
                  end else begin
                     walk_pos = 9'(nxt);
                  end
               end
            end
            default: ;
         endcase
         r.tree_ready = tree_done;
         if (r.fault == FAULT_TREE) tree_faults++;
         if (r.fault == FAULT_EARLY) early_faults++;
         expected_q = {expected_q, r};
      endfunction

      function void check_response(decode_result_type got);
         decode_result_type want;
         if (expected_q.size() == 0) begin
            $error("response beat with nothing outstanding");
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.symbol_valid !== want.symbol_valid) begin
            $error("symbol_valid: expected %0d, got %0d", want.symbol_valid, got.symbol_valid);
            errors++;
         end
         if (got.symbol !== want.symbol) begin
            $error("symbol: expected %02h, got %02h", want.symbol, got.symbol);
            errors++;
         end
         if (got.tree_ready !== want.tree_ready) begin
            $error("tree_ready: expected %0d, got %0d", want.tree_ready, got.tree_ready);
            errors++;
         end
         if (got.fault !== want.fault) begin
            $error("fault: expected %0d, got %0d", want.fault, got.fault);
            errors++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_action;
   logic [7:0] req_tree_byte;
   logic       req_code_bit;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_symbol_valid;
   logic [7:0] rsp_symbol;
   logic       rsp_tree_ready;
   logic [1:0] rsp_fault;

   decode_scoreboard_type sb;
   int burst_left;
   int sent;
   int idle_cycles;
   int stall_mode;
   int mode_left;

   huffman_tree_load_and_decode DUT (.*);

   always #10 clock = ~clock;

   // receiver stall pattern
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 35);
            2: rsp_stall <= ((mode_left % 7) < 3);
            default: rsp_stall <= ($urandom_range(0, 99) < 85);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_response({rsp_symbol_valid, rsp_symbol, rsp_tree_ready, rsp_fault});
         if (req_valid && !req_stall)
            sb.note_request(req_action, req_tree_byte, req_code_bit);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
               $display("huffman_tree_load_and_decode regression: fail");
               $finish;
            end
         end
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_beat(logic [1:0] act, logic [7:0] b, logic cb);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_action    <= act;
      req_tree_byte <= b;
      req_code_bit  <= cb;
      req_valid     <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic tree_byte_beat(logic [7:0] b);
      send_beat(ACT_TREE, b, 1'($urandom_range(0, 1)));
   endtask

   task automatic bit_beat(logic cb);
      send_beat(ACT_BIT, 8'($urandom), cb);
   endtask

   task automatic clear_beat();
      send_beat(ACT_CLEAR, 8'($urandom), 1'($urandom));
   endtask

   task automatic leaf_beats(logic [7:0] sym);
      tree_byte_beat(LEAF_FLAG);
      tree_byte_beat(sym);
   endtask

   function automatic logic [7:0] internal_flag();
      logic [7:0] b;
      do b = 8'($urandom); while (b == LEAF_FLAG);
      return b;
   endfunction

   // preorder serialization of a random tree with at most max_internal internal nodes
   task automatic load_tree(int max_internal);
      int open_slots;
      int internals;
      open_slots = 1;
      internals  = 0;
      while (open_slots > 0) begin
         if (internals < max_internal && $urandom_range(0, 99) < 55) begin
            tree_byte_beat(internal_flag());
            open_slots++;
            internals++;
         end else begin
            leaf_beats(8'($urandom));
            open_slots--;
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      int pick;
      int roll;
      int n;
      sb            = new();
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_action    = ACT_CLEAR;
      req_tree_byte = 8'h00;
      req_code_bit  = 1'b0;
      rsp_stall     = 1'b0;
      burst_left    = 0;
      sent          = 0;
      idle_cycles   = 0;
      stall_mode    = 0;
      mode_left     = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // early bits, unused action, single-leaf tree
      bit_beat(1'b0);
      bit_beat(1'b1);
      send_beat(OP_NONE, 8'hFF, 1'b1);
      leaf_beats(8'hFF);
      bit_beat(1'b0);
      bit_beat(1'b1);
      tree_byte_beat(LEAF_FLAG);
      send_beat(OP_NONE, 8'h00, 1'b0);
      clear_beat();
      // three-leaf tree, every path
      tree_byte_beat(8'h00);
      leaf_beats(8'h00);
      tree_byte_beat(8'hFE);
      leaf_beats(8'hAA);
      leaf_beats(8'h55);
      bit_beat(1'b0);
      bit_beat(1'b1);
      bit_beat(1'b0);
      bit_beat(1'b1);
      bit_beat(1'b1);
      tree_byte_beat(8'hFE);
      // clear in the middle of a load
      clear_beat();
      tree_byte_beat(8'h80);
      clear_beat();
      bit_beat(1'b1);
      drain();

      // stack overflow, then table overflow
      clear_beat();
      repeat (PEND_DEPTH) tree_byte_beat(internal_flag());
      tree_byte_beat(internal_flag());
      repeat (PEND_DEPTH - 1) leaf_beats(8'($urandom));
      tree_byte_beat(LEAF_FLAG);
      tree_byte_beat(internal_flag());
      bit_beat(1'b0);
      clear_beat();
      load_tree(40);
      repeat (30) bit_beat(1'($urandom_range(0, 1)));
      drain();

      while (sent < TOTAL_BEATS) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            if ($urandom_range(0, 9) != 0) clear_beat();
            load_tree(($urandom_range(0, 19) == 0) ? $urandom_range(20, 120)
                                                   : $urandom_range(0, 6));
            n = $urandom_range(1, 40);
            repeat (n) begin
               roll = $urandom_range(0, 99);
               if (roll < 3) send_beat(OP_NONE, 8'($urandom), 1'($urandom));
               else if (roll < 6) tree_byte_beat(8'($urandom));
               else bit_beat(1'($urandom_range(0, 1)));
            end
         end else if (pick < 90) begin
            clear_beat();
            n = $urandom_range(1, 6);
            repeat (n) begin
               if ($urandom_range(0, 1)) tree_byte_beat(internal_flag());
               else tree_byte_beat(LEAF_FLAG);
            end
            n = $urandom_range(1, 3);
            repeat (n) bit_beat(1'($urandom_range(0, 1)));
         end else begin
            n = $urandom_range(1, 5);
            repeat (n) send_beat(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
         end
         if ($urandom_range(0, 49) == 0) drain();
      end
      drain();
      repeat (20) @(negedge clock);

      if (sb.expected_q.size() != 0) begin
         $error("%0d expected responses never arrived", sb.expected_q.size());
         sb.errors++;
      end
      $display("%0d request beats, %0d trees completed, %0d symbols decoded",
               sb.beats, sb.trees_done, sb.symbols_decoded);
      $display("%0d tree faults and %0d early-bit faults checked",
               sb.tree_faults, sb.early_faults);
      if (sb.errors == 0) begin
         $display("huffman_tree_load_and_decode regression: pass");
      end else begin
         $display("huffman_tree_load_and_decode regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/hufd_pkg.sv
sv/hufd_front.sv
sv/hufd_back.sv
sv/huffman_tree_load_and_decode.sv
tb/huffman_tree_load_and_decode_test.sv
